### sv/ped_pkg.sv
`timescale 1ns / 1ps
package ped_pkg;

   localparam logic [7:0] PCT_CHAR    = 8'h25;
   localparam int         QUEUE_DEPTH = 4;

   // Pending escape state
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_PCT   = 2'd1;
   localparam logic [1:0] PEND_DIGIT = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } rsp_type;

   // Work handed from the front to the back: up to three bytes, emitted in index order
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            ends;
   } job_type;

   function automatic logic is_hex(input logic [7:0] b);
      is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_nib(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = b - 8'h30;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = b - 8'h37;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = b - 8'h57;
      end
      hex_nib = v[3:0];
   endfunction

endpackage

### sv/ped_front.sv
`timescale 1ns / 1ps
module ped_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ped_pkg::req_type  req_data,
   output logic              job_push,
   output ped_pkg::job_type  job_data,
   input  logic              queue_full
);

   logic [1:0] pend_ff, pend_in;
   logic [7:0] digit_ff, digit_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [7:0]      b;
      logic [1:0]      n;
      logic [2:0][7:0] bytes;
      logic            idle;
      b        = req_data.in_byte;
      n        = 2'd0;
      bytes    = '0;
      idle     = 1'b0;
      pend_in  = pend_ff;
      digit_in = digit_ff;

      unique case (pend_ff)
         ped_pkg::PEND_PCT: begin
            if (ped_pkg::is_hex(b)) begin
               digit_in = b;
               pend_in  = ped_pkg::PEND_DIGIT;
            end else begin
               bytes[n] = ped_pkg::PCT_CHAR;
               n        = n + 2'd1;
               idle     = 1'b1;
            end
         end
         ped_pkg::PEND_DIGIT: begin
            if (ped_pkg::is_hex(b)) begin
               bytes[n] = {ped_pkg::hex_nib(digit_ff), ped_pkg::hex_nib(b)};
               n        = n + 2'd1;
               pend_in  = ped_pkg::PEND_NONE;
            end else begin
               bytes[n] = ped_pkg::PCT_CHAR;
               n        = n + 2'd1;
               bytes[n] = digit_ff;
               n        = n + 2'd1;
               idle     = 1'b1;
            end
         end
         default: begin
            idle = 1'b1;
         end
      endcase

      // Scan the byte fresh: a '%' opens a new escape
      if (idle) begin
         if (b == ped_pkg::PCT_CHAR) begin
            pend_in = ped_pkg::PEND_PCT;
         end else begin
            pend_in  = ped_pkg::PEND_NONE;
            bytes[n] = b;
            n        = n + 2'd1;
         end
      end

      // Flush a cut-short escape raw at end of string
      if (req_data.in_end) begin
         if (pend_in == ped_pkg::PEND_PCT) begin
            bytes[n] = ped_pkg::PCT_CHAR;
            n        = n + 2'd1;
         end else if (pend_in == ped_pkg::PEND_DIGIT) begin
            bytes[n] = ped_pkg::PCT_CHAR;
            n        = n + 2'd1;
            bytes[n] = digit_in;
            n        = n + 2'd1;
         end
         pend_in  = ped_pkg::PEND_NONE;
         digit_in = 8'h00;
      end

      job_data.bytes = bytes;
      job_data.count = n;
      job_data.ends  = req_data.in_end;
      job_push       = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= ped_pkg::PEND_NONE;
         digit_ff <= 8'h00;
      end else if (accept) begin
         pend_ff  <= pend_in;
         digit_ff <= digit_in;
      end
   end

endmodule

### sv/ped_queue.sv
`timescale 1ns / 1ps
module ped_queue #(
   parameter int QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ped_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output ped_pkg::job_type  head_job,
   output logic              not_empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ped_pkg::job_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### sv/ped_back.sv
`timescale 1ns / 1ps
module ped_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  ped_pkg::job_type  job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ped_pkg::rsp_type  rsp_data
);

   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ped_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             load;
   logic             last;
   logic [7:0]       sel_byte;

   assign load = job_valid && (!rsp_valid_ff || rsp_ready);
   assign last = (idx_ff == job_data.count - 2'd1);

   always_comb begin
      unique case (idx_ff)
         2'd1:    sel_byte = job_data.bytes[1];
         2'd2:    sel_byte = job_data.bytes[2];
         default: sel_byte = job_data.bytes[0];
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = sel_byte;
         rsp_data_in.run_last    = last;
         rsp_data_in.string_done = last && job_data.ends;
         idx_in                  = last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign job_pop   = load && last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### sv/percent_escape_decoder.sv
`timescale 1ns / 1ps
// Channel  | Direction | Signals                          | Payload
// req      | in        | req_valid, req_ready, req_data   | in_byte, in_end
// rsp      | out       | rsp_valid, rsp_ready, rsp_data   | out_byte, run_last, string_done
//
// The front takes one byte per cycle while the job queue has room; each byte yields 0 to 3
// result bytes, and the back sends one result byte per cycle from the queue head while rsp_ready is high.
// An accepted byte's results are registered in the job queue and then in the output register.
// Reset (synchronous) clears the pending escape, the queue and the output valid flag.
// A stalled rsp side fills the queue; req_ready drops only when it holds QUEUE_DEPTH jobs.
module percent_escape_decoder #(
   parameter int QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ped_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ped_pkg::rsp_type  rsp_data
);

   logic             job_push;
   ped_pkg::job_type push_job;
   logic             queue_full;
   logic             job_pop;
   ped_pkg::job_type head_job;
   logic             head_valid;

   ped_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .job_push   (job_push),
      .job_data   (push_job),
      .queue_full (queue_full)
   );

   ped_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (job_pop),
      .head_job  (head_job),
      .not_empty (head_valid)
   );

   ped_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job_data  (head_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/ped_checker.sv
`timescale 1ns / 1ps
module ped_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ped_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ped_pkg::rsp_type rsp_data
);

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_done |-> rsp_data.run_last)
      else $error("string_done without run_last");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // A plain byte with nothing queued comes out through the job queue and the output register
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 (!rsp_valid && req_valid && req_ready && req_data.in_end &&
                      req_data.in_byte != ped_pkg::PCT_CHAR && !$past(req_valid && req_ready))
      |=> ##1 rsp_valid)
      else $error("result missing after a plain final byte");

endmodule

bind percent_escape_decoder ped_checker u_ped_checker (.*);
